// ----- rtl/nalu_start_code_scanner_defines.svh -----
// Assertion macros used by the checker file of the start code scanner.
`ifndef NALU_START_CODE_SCANNER_DEFINES_SVH
`define NALU_START_CODE_SCANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSC_ASSERT_NOW(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("nsc check failed");

// Next-cycle implication, checked outside reset.
`define NSC_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("nsc check failed");

`endif

// ----- rtl/nsc_pkg.sv -----
// Types and constants of the start code scanner.
`default_nettype none

package nsc_pkg;

    localparam int POS_W   = 24;   // byte position counter width (8..32)
    localparam int FIELD_W = 24;   // offset and length field width
    localparam int QDEPTH  = 4;    // front-to-back queue depth
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int SHORT_CODE_SIZE = 3;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [1:0] ZRUN_TWO  = 2'd2;
    localparam logic [1:0] ZRUN_MAX  = 2'd3;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [FIELD_W-1:0] field_t;

    // One queued result: offsets plus the end position the length runs to.
    typedef struct packed {
        logic has_record;
        logic final_flag;
        pos_t code_offset;
        pos_t payload_offset;
        pos_t end_pos;
    } nsc_entry_t;

    // Zero-extend or truncate a position to the output field width.
    function automatic field_t to_field(input pos_t v);
        field_t r;
        r = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (i < POS_W) begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nsc_front.sv -----
// Front end: tracks position and zero run, detects start codes, queues results.
`default_nettype none

module nsc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic               q_space,
    output logic                    push,
    output nsc_pkg::nsc_entry_t     push_entry
);

    nsc_pkg::pos_t pos_reg, pos_next;
    logic [1:0]    zrun_reg, zrun_next;
    logic          pend_reg, pend_next;
    nsc_pkg::pos_t pcode_reg, pcode_next;
    nsc_pkg::pos_t ppay_reg, ppay_next;

    logic          accept;
    logic          start_hit;
    nsc_pkg::pos_t code_pos;
    nsc_pkg::pos_t pos_inc;

    assign in_ready = q_space;
    assign accept   = in_valid && q_space;
    assign pos_inc  = pos_reg + nsc_pkg::POS_W'(1);
    assign start_hit = (data_byte == nsc_pkg::BYTE_ONE) && (zrun_reg >= nsc_pkg::ZRUN_TWO);
    assign code_pos  = (zrun_reg == nsc_pkg::ZRUN_MAX)
                     ? pos_reg - nsc_pkg::POS_W'(nsc_pkg::SHORT_CODE_SIZE)
                     : pos_reg - nsc_pkg::POS_W'(nsc_pkg::SHORT_CODE_SIZE - 1);

    always_comb
    begin
        pos_next   = pos_reg;
        zrun_next  = zrun_reg;
        pend_next  = pend_reg;
        pcode_next = pcode_reg;
        ppay_next  = ppay_reg;
        push       = 1'b0;
        push_entry = '0;

        if (accept) begin
            if (last_byte) begin
                // Close the open record at the buffer end, then start over.
                push                 = 1'b1;
                push_entry.final_flag = 1'b1;
                if (pend_reg) begin
                    push_entry.has_record     = 1'b1;
                    push_entry.code_offset    = pcode_reg;
                    push_entry.payload_offset = ppay_reg;
                    push_entry.end_pos        = pos_inc;
                end
                pos_next   = '0;
                zrun_next  = '0;
                pend_next  = 1'b0;
                pcode_next = '0;
                ppay_next  = '0;
            end else begin
                if (start_hit) begin
                    if (pend_reg) begin
                        push                      = 1'b1;
                        push_entry.has_record     = 1'b1;
                        push_entry.code_offset    = pcode_reg;
                        push_entry.payload_offset = ppay_reg;
                        push_entry.end_pos        = code_pos;
                    end
                    pend_next  = 1'b1;
                    pcode_next = code_pos;
                    ppay_next  = pos_inc;
                end
                if (data_byte == nsc_pkg::BYTE_ZERO) begin
                    if (zrun_reg != nsc_pkg::ZRUN_MAX) begin
                        zrun_next = zrun_reg + 2'd1;
                    end
                end else begin
                    zrun_next = '0;
                end
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            zrun_reg  <= '0;
            pend_reg  <= 1'b0;
            pcode_reg <= '0;
            ppay_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            zrun_reg  <= zrun_next;
            pend_reg  <= pend_next;
            pcode_reg <= pcode_next;
            ppay_reg  <= ppay_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nsc_queue.sv -----
// Short queue between the front end and the back end.
`default_nettype none

module nsc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire nsc_pkg::nsc_entry_t push_entry,
    output logic                    space,
    input  wire logic               pop,
    output logic                    head_valid,
    output nsc_pkg::nsc_entry_t     head_entry
);

    nsc_pkg::nsc_entry_t           entry_reg [nsc_pkg::QDEPTH];
    logic [nsc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [nsc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [nsc_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign space      = (count_reg != nsc_pkg::QCNT_W'(nsc_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + nsc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + nsc_pkg::QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + nsc_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - nsc_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nsc_back.sv -----
// Back end: computes the payload length and holds the result register.
`default_nettype none

module nsc_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_valid,
    input  wire nsc_pkg::nsc_entry_t        head_entry,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            has_record,
    output logic [nsc_pkg::FIELD_W-1:0]     code_offset,
    output logic [nsc_pkg::FIELD_W-1:0]     payload_offset,
    output logic [nsc_pkg::FIELD_W-1:0]     payload_length,
    output logic                            final_result
);

    logic             valid_reg;
    logic             has_reg;
    logic             final_reg;
    nsc_pkg::field_t  code_reg;
    nsc_pkg::field_t  pay_reg;
    nsc_pkg::field_t  len_reg;
    nsc_pkg::pos_t    len_pos;

    // Load a new result whenever the register is empty or being drained.
    assign pop     = head_valid && (!valid_reg || out_ready);
    assign len_pos = head_entry.end_pos - head_entry.payload_offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            has_reg   <= head_entry.has_record;
            final_reg <= head_entry.final_flag;
            code_reg  <= nsc_pkg::to_field(head_entry.code_offset);
            pay_reg   <= nsc_pkg::to_field(head_entry.payload_offset);
            len_reg   <= nsc_pkg::to_field(len_pos);
        end
    end

    assign out_valid      = valid_reg;
    assign has_record     = has_reg;
    assign final_result   = final_reg;
    assign code_offset    = code_reg;
    assign payload_offset = pay_reg;
    assign payload_length = len_reg;

endmodule

`default_nettype wire

// ----- rtl/nalu_start_code_scanner.sv -----
// Top level of the H.264 Annex B start code scanner.
//
//  Channel | Signals                                   | Role
//  --------+-------------------------------------------+-------------------------
//  input   | in_valid, in_ready, data_byte, last_byte  | one stream byte per transaction
//  output  | out_valid, out_ready, has_record,         | one NAL unit record or final
//          | code_offset, payload_offset,              | result per transaction
//          | payload_length, final_result              |
//
// One byte is taken per cycle while in_ready is high. A result passes from the byte
// that causes it into the queue, then into the output register, where the payload
// length subtract sits.
// rst_n clears the position counter, zero run, open record and queue at once.
// A stalled output fills the four-entry queue; in_ready drops only while the
// queue is full, so bytes that cause no result still need a free slot.
`default_nettype none

module nalu_start_code_scanner (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       last_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            has_record,
    output logic [nsc_pkg::FIELD_W-1:0]     code_offset,
    output logic [nsc_pkg::FIELD_W-1:0]     payload_offset,
    output logic [nsc_pkg::FIELD_W-1:0]     payload_length,
    output logic                            final_result
);

    // Front to queue
    logic                push;
    nsc_pkg::nsc_entry_t push_entry;
    logic                q_space;

    // Queue to back
    logic                pop;
    logic                head_valid;
    nsc_pkg::nsc_entry_t head_entry;

    // Classify each byte: detect start codes, track the open record,
    // and emit a closed record or final result into the queue.
    nsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .q_space    (q_space),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the two sides so an output stall does not stop byte intake
    // until the queue fills.
    nsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Finish each record: compute its length and hold it for the consumer.
    nsc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .has_record     (has_record),
        .code_offset    (code_offset),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .final_result   (final_result)
    );

endmodule

`default_nettype wire

// ----- rtl/nsc_checker.sv -----
// Port-level checks of the start code scanner and their bind.
`default_nettype none

`include "nalu_start_code_scanner_defines.svh"

module nsc_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic                       has_record,
    input  wire logic [nsc_pkg::FIELD_W-1:0] code_offset,
    input  wire logic [nsc_pkg::FIELD_W-1:0] payload_offset,
    input  wire logic [nsc_pkg::FIELD_W-1:0] payload_length,
    input  wire logic                       final_result
);

    logic [nsc_pkg::FIELD_W-1:0] code_span;
    logic                        fields_zero;
    logic                        span_ok;

    assign code_span   = payload_offset - code_offset;
    assign fields_zero = (code_offset == '0) && (payload_offset == '0)
                      && (payload_length == '0);
    assign span_ok     = (code_span == nsc_pkg::FIELD_W'(3))
                      || (code_span == nsc_pkg::FIELD_W'(4));

    `NSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `NSC_ASSERT_NEXT(a_len_hold, clk, rst_n, out_valid && !out_ready, $stable(payload_length))
    `NSC_ASSERT_NOW(a_empty_is_final, clk, rst_n, out_valid && !has_record, final_result)
    `NSC_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !has_record, fields_zero)
    `NSC_ASSERT_NOW(a_code_span, clk, rst_n, out_valid && has_record, span_ok)

endmodule

bind nalu_start_code_scanner nsc_checker u_nsc_checker (.*);

`default_nettype wire
